[rtl/bloom_filter_double_hash_unit_macros.svh]
`ifndef BLOOM_FILTER_DOUBLE_HASH_UNIT_MACROS_SVH
`define BLOOM_FILTER_DOUBLE_HASH_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BFDH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BFDH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bfdh_pkg.sv]
`timescale 1ns / 1ps

package bfdh_pkg;

    localparam int MAX_FILTER_BITS = 65536;
    localparam int STORE_BYTES     = (MAX_FILTER_BITS + 7) / 8;
    localparam int ADDR_W          = $clog2(STORE_BYTES);
    localparam int REM_W           = $clog2(MAX_FILTER_BITS);
    localparam int M_W             = $clog2(MAX_FILTER_BITS + 1);
    localparam int CMP_W           = M_W + 1;

    localparam int TABLE_W    = 17;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam int MIN_TABLE_BITS = 64;
    localparam int MIN_PROBES     = 1;
    localparam int MAX_PROBES     = 30;

    localparam logic [TABLE_W-1:0] TABLE_RESET = TABLE_W'(65536);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(7);

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_BITS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = CFG_IDX_W'(1);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [63:0] XP1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] XP2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] XP3 = 64'h165667B19E3779F9;
    localparam logic [63:0] XP4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] XP5 = 64'h27D4EB2F165667C5;
    localparam logic [63:0] SEED_BASE = XP5 + 64'd8;

    typedef struct packed {
        logic        opcode;
        logic [63:0] key;
    } cmd_t;

    typedef struct packed {
        logic op_done;
        logic maybe_present;
    } result_t;

    typedef enum logic [2:0] {
        MS_K1 = 3'd0,
        MS_K2 = 3'd1,
        MS_H1 = 3'd2,
        MS_H2 = 3'd3,
        MS_H3 = 3'd4
    } mul_sel_t;

    typedef enum logic [1:0] {
        MOD_H1   = 2'd0,
        MOD_H2   = 2'd1,
        MOD_ONES = 2'd2
    } mod_src_t;

    typedef struct packed {
        logic       load;
        logic       clear_step;
        logic       mul_en;
        mul_sel_t   mul_sel;
        logic [1:0] mul_phase;
        logic       seed;
        logic       mod_load;
        logic       mod_step;
        logic       mod_store;
        mod_src_t   mod_src;
        logic       probe_init;
        logic       probe_step;
        logic       bit_set;
    } ctl_t;

    typedef struct packed {
        logic               clear_last;
        logic               bit_hit;
        logic [COUNT_W-1:0] k_eff;
    } sts_t;

endpackage

[rtl/bfdh_ram.sv]
`timescale 1ns / 1ps

module bfdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bfdh_datapath.sv]
`timescale 1ns / 1ps
`include "bloom_filter_double_hash_unit_macros.svh"

module bfdh_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfdh_pkg::ctl_t                ctl,
    output bfdh_pkg::sts_t                sts,
    input  logic [63:0]                   key,
    input  logic                          cfg_we,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfdh_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bfdh_pkg::*;

    logic [TABLE_W-1:0] table_bits_reg;
    logic [COUNT_W-1:0] hash_count_reg;
    logic [31:0]        m32;
    logic [M_W-1:0]     m_eff;
    logic [COUNT_W-1:0] k_eff;

    logic [63:0] key_reg, v_reg, kval_reg, h1_reg, h2_reg;
    logic [63:0] mul_a, mul_b, full, post_t;
    logic [31:0] mul_x, mul_y, cross_reg;
    logic [63:0] prod_reg, lo_reg;
    logic [63:0] d_reg, x_reg;
    logic [REM_W-1:0] rem_reg, r1_reg, r2_reg, w_reg, r_reg;
    logic [CMP_W-1:0] trial, rem_nx, w_nx, s0, s1, r_nx;
    logic [64:0]      x_sum;
    logic [ADDR_W-1:0] clr_reg, ram_addr;
    logic [7:0]        mask, rdata, wdata;
    logic              ram_we;

    // configuration and saturation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_bits_reg <= TABLE_RESET;
            hash_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TABLE_BITS)
            begin
                table_bits_reg <= TABLE_W'(cfg_data);
            end
            else if (cfg_index == REG_HASH_COUNT)
            begin
                hash_count_reg <= COUNT_W'(cfg_data);
            end
        end
    end

    always_comb
    begin
        priority if (32'(table_bits_reg) < 32'(MIN_TABLE_BITS))
            m32 = 32'(MIN_TABLE_BITS);
        else if (32'(table_bits_reg) > 32'(MAX_FILTER_BITS))
            m32 = 32'(MAX_FILTER_BITS);
        else
            m32 = 32'(table_bits_reg);
        priority if (hash_count_reg < COUNT_W'(MIN_PROBES))
            k_eff = COUNT_W'(MIN_PROBES);
        else if (hash_count_reg > COUNT_W'(MAX_PROBES))
            k_eff = COUNT_W'(MAX_PROBES);
        else
            k_eff = hash_count_reg;
    end
    assign m_eff = M_W'(m32);

    assign post_t = (SEED_BASE + 64'(ctl.seed)) ^ kval_reg;

    // shared 32x32 multiplier, one partial product per beat
    always_comb
    begin
        unique case (ctl.mul_sel)
            MS_K1:
            begin
                mul_a = key_reg;
                mul_b = XP2;
            end
            MS_K2:
            begin
                mul_a = {v_reg[32:0], v_reg[63:33]};
                mul_b = XP1;
            end
            MS_H1:
            begin
                mul_a  = {post_t[36:0], post_t[63:37]};
                mul_b  = XP1;
            end
            MS_H2:
            begin
                mul_a = v_reg;
                mul_b = XP2;
            end
            MS_H3:
            begin
                mul_a = v_reg;
                mul_b = XP3;
            end
            default:
            begin
                mul_a = v_reg;
                mul_b = XP1;
            end
        endcase
    end

    always_comb
    begin
        unique case (ctl.mul_phase)
            2'd1:
            begin
                mul_x = mul_a[31:0];
                mul_y = mul_b[63:32];
            end
            2'd2:
            begin
                mul_x = mul_a[63:32];
                mul_y = mul_b[31:0];
            end
            default:
            begin
                mul_x = mul_a[31:0];
                mul_y = mul_b[31:0];
            end
        endcase
    end

    assign full = lo_reg + {cross_reg + prod_reg[31:0], 32'd0};

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg <= key;
        end
        if (ctl.mul_en)
        begin
            prod_reg <= 64'(mul_x) * 64'(mul_y);
            if (ctl.mul_phase == 2'd1)
            begin
                lo_reg <= prod_reg;
            end
            if (ctl.mul_phase == 2'd2)
            begin
                cross_reg <= prod_reg[31:0];
            end
            if (ctl.mul_phase == 2'd3)
            begin
                unique case (ctl.mul_sel)
                    MS_K1: v_reg <= full;
                    MS_K2: kval_reg <= full;
                    MS_H1: v_reg <= (full + XP4) ^ ((full + XP4) >> 33);
                    MS_H2: v_reg <= full ^ (full >> 29);
                    MS_H3:
                    begin
                        if (ctl.seed)
                            h2_reg <= full ^ (full >> 32);
                        else
                            h1_reg <= full ^ (full >> 32);
                    end
                    default: v_reg <= full;
                endcase
            end
        end
    end

    // bit-serial restoring remainder by m
    assign trial  = CMP_W'({rem_reg, d_reg[63]});
    assign rem_nx = (trial >= CMP_W'(m_eff)) ? trial - CMP_W'(m_eff) : trial;
    assign w_nx   = (rem_nx + CMP_W'(1) == CMP_W'(m_eff)) ? '0 : rem_nx + CMP_W'(1);

    // running probe: x = h1 + i*h2 mod 2^64, r = x mod m
    assign x_sum = {1'b0, x_reg} + {1'b0, h2_reg};
    assign s0    = CMP_W'(r_reg) + CMP_W'(r2_reg);
    assign s1    = (s0 >= CMP_W'(m_eff)) ? s0 - CMP_W'(m_eff) : s0;
    always_comb
    begin
        if (!x_sum[64])
            r_nx = s1;
        else if (s1 >= CMP_W'(w_reg))
            r_nx = s1 - CMP_W'(w_reg);
        else
            r_nx = s1 + CMP_W'(m_eff) - CMP_W'(w_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mod_load)
        begin
            unique case (ctl.mod_src)
                MOD_H1:  d_reg <= h1_reg;
                MOD_H2:  d_reg <= h2_reg;
                default: d_reg <= '1;
            endcase
            rem_reg <= '0;
        end
        else if (ctl.mod_step)
        begin
            d_reg   <= {d_reg[62:0], 1'b0};
            rem_reg <= REM_W'(rem_nx);
        end
        if (ctl.mod_store)
        begin
            unique case (ctl.mod_src)
                MOD_H1:  r1_reg <= REM_W'(rem_nx);
                MOD_H2:  r2_reg <= REM_W'(rem_nx);
                default: w_reg  <= REM_W'(w_nx);
            endcase
        end
        if (ctl.probe_init)
        begin
            x_reg <= h1_reg;
            r_reg <= r1_reg;
        end
        else if (ctl.probe_step)
        begin
            x_reg <= x_sum[63:0];
            r_reg <= REM_W'(r_nx);
        end
    end

    // clear sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (ctl.clear_step)
        begin
            clr_reg <= clr_reg + ADDR_W'(1);
        end
    end

    assign mask     = 8'd1 << r_reg[2:0];
    assign ram_addr = ctl.clear_step ? clr_reg : ADDR_W'(r_reg >> 3);
    assign ram_we   = ctl.clear_step | ctl.bit_set;
    assign wdata    = ctl.clear_step ? 8'd0 : (rdata | mask);

    bfdh_ram #(
        .WIDTH(8),
        .DEPTH(STORE_BYTES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(wdata),
        .rdata(rdata)
    );

    assign sts.clear_last = (clr_reg == ADDR_W'(STORE_BYTES - 1));
    assign sts.bit_hit    = ((rdata & mask) != 8'd0);
    assign sts.k_eff      = k_eff;

    `BFDH_ASSERT_NXT(a_probe_in_range, ctl.probe_step, CMP_W'(r_reg) < CMP_W'(m_eff), "probe index not below table size")
    `BFDH_ASSERT_IMP(a_write_source, ram_we, !(ctl.clear_step && ctl.bit_set), "clear sweep and probe write collide")

endmodule

[rtl/bfdh_ctrl.sv]
`timescale 1ns / 1ps
`include "bloom_filter_double_hash_unit_macros.svh"

module bfdh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              opcode,
    output logic              busy,
    output logic              done,
    output bfdh_pkg::result_t result,
    output bfdh_pkg::ctl_t    ctl,
    input  bfdh_pkg::sts_t    sts
);
    import bfdh_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR   = 6'b000001,
        S_IDLE    = 6'b000010,
        S_MUL     = 6'b000100,
        S_MOD     = 6'b001000,
        S_PRB_RD  = 6'b010000,
        S_PRB_CHK = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         mul_idx_reg, mul_idx_next;
    logic [1:0]         phase_reg, phase_next;
    logic [1:0]         mod_idx_reg, mod_idx_next;
    logic [6:0]         bit_cnt_reg, bit_cnt_next;
    logic [COUNT_W-1:0] probe_reg, probe_next;
    logic               op_reg, op_next;
    logic               done_reg, done_next;
    result_t            result_reg, result_next;
    logic               miss, last;

    assign miss = (op_reg == OP_QUERY) && !sts.bit_hit;
    assign last = (probe_reg == sts.k_eff - COUNT_W'(1));

    always_comb
    begin
        state_next   = state_reg;
        mul_idx_next = mul_idx_reg;
        phase_next   = phase_reg;
        mod_idx_next = mod_idx_reg;
        bit_cnt_next = bit_cnt_reg;
        probe_next   = probe_reg;
        op_next      = op_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        ctl          = '0;
        ctl.mul_sel  = MS_K1;
        ctl.mod_src  = MOD_H1;

        unique case (mul_idx_reg)
            3'd0: ctl.mul_sel = MS_K1;
            3'd1: ctl.mul_sel = MS_K2;
            3'd2, 3'd5: ctl.mul_sel = MS_H1;
            3'd3, 3'd6: ctl.mul_sel = MS_H2;
            default: ctl.mul_sel = MS_H3;
        endcase
        ctl.seed      = (mul_idx_reg >= 3'd5);
        ctl.mul_phase = phase_reg;
        unique case (mod_idx_reg)
            2'd0:    ctl.mod_src = MOD_H1;
            2'd1:    ctl.mod_src = MOD_H2;
            default: ctl.mod_src = MOD_ONES;
        endcase

        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clear_step = 1'b1;
                if (sts.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load     = 1'b1;
                    op_next      = opcode;
                    mul_idx_next = '0;
                    phase_next   = '0;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                ctl.mul_en = 1'b1;
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    mul_idx_next = mul_idx_reg + 3'd1;
                    if (mul_idx_reg == 3'd7)
                    begin
                        mod_idx_next = '0;
                        bit_cnt_next = '0;
                        state_next   = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                bit_cnt_next = bit_cnt_reg + 7'd1;
                if (bit_cnt_reg == 7'd0)
                    ctl.mod_load = 1'b1;
                else
                    ctl.mod_step = 1'b1;
                if (bit_cnt_reg == 7'd64)
                begin
                    ctl.mod_store = 1'b1;
                    bit_cnt_next  = '0;
                    mod_idx_next  = mod_idx_reg + 2'd1;
                    if (mod_idx_reg == 2'd2)
                    begin
                        ctl.probe_init = 1'b1;
                        probe_next     = '0;
                        state_next     = S_PRB_RD;
                    end
                end
            end
            S_PRB_RD:
            begin
                state_next = S_PRB_CHK;
            end
            S_PRB_CHK:
            begin
                ctl.probe_step = 1'b1;
                ctl.bit_set    = (op_reg == OP_ADD);
                if (last || miss)
                begin
                    done_next                 = 1'b1;
                    result_next.op_done       = op_reg;
                    result_next.maybe_present = (op_reg == OP_QUERY) && !miss;
                    state_next                = S_IDLE;
                end
                else
                begin
                    probe_next = probe_reg + COUNT_W'(1);
                    state_next = S_PRB_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            mul_idx_reg <= '0;
            phase_reg   <= '0;
            mod_idx_reg <= '0;
            bit_cnt_reg <= '0;
            probe_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mul_idx_reg <= mul_idx_next;
            phase_reg   <= phase_next;
            mod_idx_reg <= mod_idx_next;
            bit_cnt_reg <= bit_cnt_next;
            probe_reg   <= probe_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `BFDH_ASSERT_NXT(a_accept_to_mul, state_reg == S_IDLE && start, state_reg == S_MUL && mul_idx_reg == 3'd0 && phase_reg == 2'd0, "accepted beat did not start hashing")
    `BFDH_ASSERT_IMP(a_done_after_probe, done_reg, $past(state_reg) == S_PRB_CHK, "result strobe without probe check")
    `BFDH_ASSERT_IMP(a_present_only_query, done_reg && result_reg.maybe_present, result_reg.op_done == OP_QUERY, "add reported present")

endmodule

[rtl/bloom_filter_double_hash_unit.sv]
`timescale 1ns / 1ps

// Bloom filter with two XXH64 hashes (seeds 0 and 1) of a 64-bit key. After reset
// the block sweeps the 8192-byte bit store to zero, one byte a cycle, keeping busy
// high until the sweep ends. An item is taken when start is high and busy low; one
// result follows on done for a single cycle and the receiver cannot hold it off.
// An item is hashed with eight 64-bit products on one shared 32x32 multiplier, is
// reduced by three bit-serial remainders by the table size, then makes p probes, p
// being hash_count clamped to 1..30, or fewer when a query hits a clear bit; each
// probe is a read then a write or check on the store port.
module bloom_filter_double_hash_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  bfdh_pkg::cmd_t                  cmd,
    output logic                            done,
    output bfdh_pkg::result_t               result,
    input  logic                            cfg_we,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfdh_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bfdh_pkg::*;

    ctl_t ctl;
    sts_t sts;

    bfdh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .opcode(cmd.opcode),
        .busy  (busy),
        .done  (done),
        .result(result),
        .ctl   (ctl),
        .sts   (sts)
    );

    bfdh_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sts      (sts),
        .key      (cmd.key),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

endmodule
